@@ src/pudt_pkg.sv @@
// Shared types, register map and constants for the prescaled up/down timer.
package pudt_pkg;

  // Default width of the main counter and the auto-reload registers
  localparam int DEF_COUNT_WIDTH = 16;

  // Bus-side data width
  localparam int DATA_WIDTH = 16;

  // Request kinds carried by one input transaction
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_IDLE  = 2'd3
  } req_kind_t;

  // Register map
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_INT_EN   = 3'd1,
    REG_STATUS   = 3'd2,
    REG_COUNTER  = 3'd3,
    REG_PRESCALE = 3'd4,
    REG_RELOAD   = 3'd5,
    REG_RSVD6    = 3'd6,
    REG_RSVD7    = 3'd7
  } reg_sel_t;

  // Bit positions within the control, interrupt enable and status registers
  localparam int CTRL_EN_BIT      = 0;
  localparam int CTRL_DOWN_BIT    = 4;
  localparam int CTRL_PRELOAD_BIT = 7;
  localparam int INT_EN_UPD_BIT   = 0;
  localparam int STATUS_UPD_BIT   = 0;

  // Input transaction
  typedef struct packed {
    logic [1:0]            req_type;
    logic [2:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_value;
  } req_item_t;

  // Result transaction
  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_value;
    logic                  irq_pending;
    logic                  update_event;
  } rsp_item_t;

endpackage

@@ src/pudt_core.sv @@
// Timer register file and combinational update logic for one transaction.
module pudt_core import pudt_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  req_item_t item,
  output rsp_item_t result
);

  localparam int EXT_WIDTH = COUNT_WIDTH + DATA_WIDTH;

  // Architectural state
  logic                   run_enable, count_down, reload_preload_on;
  logic                   update_irq_enable, update_flag;
  logic [DATA_WIDTH-1:0]  prescale_limit, prescale_count;
  logic [COUNT_WIDTH-1:0] main_count, reload_written, reload_active;

  logic                   run_enable_next, count_down_next, reload_preload_on_next;
  logic                   update_irq_enable_next, update_flag_next;
  logic [DATA_WIDTH-1:0]  prescale_limit_next, prescale_count_next;
  logic [COUNT_WIDTH-1:0] main_count_next, reload_written_next, reload_active_next;

  logic [EXT_WIDTH-1:0]   wr_ext, cnt_ext, rld_ext;
  logic [COUNT_WIDTH-1:0] wr_cnt, reload_new;
  logic [DATA_WIDTH-1:0]  rd_value;
  logic                   wrapped;

  // Width adaption between the bus and the counter
  assign wr_ext  = {{COUNT_WIDTH{1'b0}}, item.write_value};
  assign wr_cnt  = wr_ext[COUNT_WIDTH-1:0];
  assign cnt_ext = {{DATA_WIDTH{1'b0}}, main_count};
  assign rld_ext = {{DATA_WIDTH{1'b0}}, reload_written};

  // Active reload value as seen at an update
  assign reload_new = reload_preload_on ? reload_written : reload_active;

  // Next-state logic for one transaction
  always_comb begin
    run_enable_next        = run_enable;
    count_down_next        = count_down;
    reload_preload_on_next = reload_preload_on;
    update_irq_enable_next = update_irq_enable;
    update_flag_next       = update_flag;
    prescale_limit_next    = prescale_limit;
    prescale_count_next    = prescale_count;
    main_count_next        = main_count;
    reload_written_next    = reload_written;
    reload_active_next     = reload_active;
    wrapped                = 1'b0;
    rd_value               = '0;

    unique case (req_kind_t'(item.req_type))
      REQ_TICK: begin
        if (run_enable) begin
          if (prescale_count >= prescale_limit) begin
            prescale_count_next = '0;
            if (count_down) begin
              if (main_count == '0) begin
                wrapped            = 1'b1;
                reload_active_next = reload_new;
                main_count_next    = reload_new;
              end else begin
                main_count_next = main_count - 1'b1;
              end
            end else begin
              if (main_count == reload_active) begin
                wrapped            = 1'b1;
                reload_active_next = reload_new;
                main_count_next    = '0;
              end else begin
                main_count_next = main_count + 1'b1;
              end
            end
            if (wrapped) begin
              update_flag_next = 1'b1;
            end
          end else begin
            prescale_count_next = prescale_count + 1'b1;
          end
        end
      end
      REQ_READ: begin
        unique case (reg_sel_t'(item.reg_index))
          REG_CTRL: begin
            rd_value[CTRL_EN_BIT]      = run_enable;
            rd_value[CTRL_DOWN_BIT]    = count_down;
            rd_value[CTRL_PRELOAD_BIT] = reload_preload_on;
          end
          REG_INT_EN:   rd_value[INT_EN_UPD_BIT] = update_irq_enable;
          REG_STATUS:   rd_value[STATUS_UPD_BIT] = update_flag;
          REG_COUNTER:  rd_value = cnt_ext[DATA_WIDTH-1:0];
          REG_PRESCALE: rd_value = prescale_limit;
          REG_RELOAD:   rd_value = rld_ext[DATA_WIDTH-1:0];
          default:      rd_value = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (reg_sel_t'(item.reg_index))
          REG_CTRL: begin
            run_enable_next        = item.write_value[CTRL_EN_BIT];
            count_down_next        = item.write_value[CTRL_DOWN_BIT];
            reload_preload_on_next = item.write_value[CTRL_PRELOAD_BIT];
          end
          REG_INT_EN: update_irq_enable_next = item.write_value[INT_EN_UPD_BIT];
          REG_STATUS: begin
            // write 0 clears, write 1 leaves the flag alone
            if (!item.write_value[STATUS_UPD_BIT]) begin
              update_flag_next = 1'b0;
            end
          end
          REG_COUNTER:  main_count_next     = wr_cnt;
          REG_PRESCALE: prescale_limit_next = item.write_value;
          REG_RELOAD: begin
            reload_written_next = wr_cnt;
            if (!reload_preload_on) begin
              reload_active_next = wr_cnt;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result seen after this transaction
  always_comb begin
    result.read_value   = rd_value;
    result.irq_pending  = update_flag_next & update_irq_enable_next;
    result.update_event = wrapped;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable        <= 1'b0;
      count_down        <= 1'b0;
      reload_preload_on <= 1'b0;
      update_irq_enable <= 1'b0;
      update_flag       <= 1'b0;
      prescale_limit    <= '0;
      prescale_count    <= '0;
      main_count        <= '0;
      reload_written    <= '1;
      reload_active     <= '1;
    end else if (fire) begin
      run_enable        <= run_enable_next;
      count_down        <= count_down_next;
      reload_preload_on <= reload_preload_on_next;
      update_irq_enable <= update_irq_enable_next;
      update_flag       <= update_flag_next;
      prescale_limit    <= prescale_limit_next;
      prescale_count    <= prescale_count_next;
      main_count        <= main_count_next;
      reload_written    <= reload_written_next;
      reload_active     <= reload_active_next;
    end
  end

endmodule

@@ src/prescaled_up_down_timer_core.sv @@
// Top level of the prescaled up/down timer: input register, core and result register.
//
// Every transaction (tick, register read, register write or idle) gives one result.
// The block takes one transaction per clock cycle as long as the result side does
// not stall; each passes through the input register and then the timer core,
// whose state and result register are updated together. The whole timer
// update (prescale compare, counter step, reload and flag) settles in the
// core's combinational next-state logic. COUNT_WIDTH sets the main counter and
// auto-reload width; reads return its low 16 bits and writes are zero
// extended or truncated to it. irq_pending is the update flag AND the
// interrupt enable after the transaction.
module prescaled_up_down_timer_core import pudt_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  logic      s1_valid;
  req_item_t s1_item;
  logic      advance;
  logic      fire;
  rsp_item_t core_result;

  // Pipeline moves when the result register is free or being drained
  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && advance;
  assign req_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_item <= req;
    end
  end

  pudt_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (s1_item),
    .result(core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= core_result;
    end
  end

endmodule

@@ src/pudt_checker.sv @@
// Port-level checks for the prescaled up/down timer, bound to the top level.
module pudt_checker import pudt_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  // A held result keeps its valid
  a_rsp_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result valid dropped while stalled");

  // A held result keeps its payload
  a_rsp_data_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("result payload changed while stalled");

  // Input side only stalls because a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without a held result");

  // A fresh result follows an accepted transaction
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
    else $error("result appeared without an accepted transaction");

endmodule

bind prescaled_up_down_timer_core pudt_checker u_pudt_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

@@ dv/prescaled_up_down_timer_core_tb.sv @@
// Self-checking testbench for the prescaled up/down timer core.
`timescale 1ns / 1ps

module prescaled_up_down_timer_core_tb;
  import pudt_pkg::*;

  localparam int CW           = DEF_COUNT_WIDTH;
  localparam int N_RANDOM     = 1200;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  // Shadow copy of the timer: predicts each result and checks the block's output
  class timer_shadow;
    logic          run_en;
    logic          count_down;
    logic          preload_on;
    logic          irq_en;
    logic          upd_flag;
    logic [15:0]   psc_limit;
    logic [15:0]   psc_count;
    logic [CW-1:0] main_count;
    logic [CW-1:0] reload_written;
    logic [CW-1:0] reload_active;
    rsp_item_t     pending_results[$];
    int            error_count;
    int            req_count;
    int            rsp_count;
    int            wrap_count;
    int            irq_count;

    function new();
      run_en         = 1'b0;
      count_down     = 1'b0;
      preload_on     = 1'b0;
      irq_en         = 1'b0;
      upd_flag       = 1'b0;
      psc_limit      = '0;
      psc_count      = '0;
      main_count     = '0;
      reload_written = '1;
      reload_active  = '1;
      error_count    = 0;
      req_count      = 0;
      rsp_count      = 0;
      wrap_count     = 0;
      irq_count      = 0;
    endfunction

    // One clock tick; returns 1 when the counter wrapped
    function logic advance_tick();
      logic wrapped;
      wrapped = 1'b0;
      if (!run_en) return 1'b0;
      if (psc_count >= psc_limit) begin
        psc_count = '0;
        if (count_down) begin
          if (main_count == '0) begin
            wrapped = 1'b1;
            if (preload_on) reload_active = reload_written;
            main_count = reload_active;
          end else begin
            main_count = main_count - 1'b1;
          end
        end else begin
          if (main_count == reload_active) begin
            wrapped = 1'b1;
            if (preload_on) reload_active = reload_written;
            main_count = '0;
          end else begin
            // past the reload value this rolls over silently
            main_count = main_count + 1'b1;
          end
        end
        if (wrapped) upd_flag = 1'b1;
      end else begin
        psc_count = psc_count + 1'b1;
      end
      return wrapped;
    endfunction

    function logic [15:0] read_register(logic [2:0] idx);
      logic [15:0] value;
      value = '0;
      case (idx)
        REG_CTRL: begin
          value[CTRL_EN_BIT]      = run_en;
          value[CTRL_DOWN_BIT]    = count_down;
          value[CTRL_PRELOAD_BIT] = preload_on;
        end
        REG_INT_EN:   value[INT_EN_UPD_BIT] = irq_en;
        REG_STATUS:   value[STATUS_UPD_BIT] = upd_flag;
        REG_COUNTER:  value = 16'(main_count);
        REG_PRESCALE: value = psc_limit;
        REG_RELOAD:   value = 16'(reload_written);
        default:      value = '0;
      endcase
      return value;
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_CTRL: begin
          run_en     = value[CTRL_EN_BIT];
          count_down = value[CTRL_DOWN_BIT];
          preload_on = value[CTRL_PRELOAD_BIT];
        end
        REG_INT_EN: irq_en = value[INT_EN_UPD_BIT];
        // writing a 1 leaves the flag alone
        REG_STATUS: if (!value[STATUS_UPD_BIT]) upd_flag = 1'b0;
        REG_COUNTER:  main_count = CW'(value);
        REG_PRESCALE: psc_limit = value;
        REG_RELOAD: begin
          reload_written = CW'(value);
          if (!preload_on) reload_active = reload_written;
        end
        default: ;
      endcase
    endfunction

    // Accepted request: step the shadow and queue the result it should give
    function void note_request(req_item_t item);
      rsp_item_t res;
      res = '0;
      case (item.req_type)
        REQ_TICK:  res.update_event = advance_tick();
        REQ_READ:  res.read_value = read_register(item.reg_index);
        REQ_WRITE: write_register(item.reg_index, item.write_value);
        default: ;
      endcase
      res.irq_pending = upd_flag & irq_en;
      if (res.update_event) wrap_count++;
      if (res.irq_pending) irq_count++;
      req_count++;
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
    endtask

    task check_result(rsp_item_t got);
      rsp_item_t want;
      rsp_count++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", rsp_count));
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value)
        report($sformatf("result %0d read_value %h, predicted %h",
                         rsp_count, got.read_value, want.read_value));
      if (got.irq_pending !== want.irq_pending)
        report($sformatf("result %0d irq_pending %b, predicted %b",
                         rsp_count, got.irq_pending, want.irq_pending));
      if (got.update_event !== want.update_event)
        report($sformatf("result %0d update_event %b, predicted %b",
                         rsp_count, got.update_event, want.update_event));
    endtask
  endclass

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  timer_shadow sb;
  bit          idling_on = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;

  prescaled_up_down_timer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic req_item_t make_req(req_kind_t kind, reg_sel_t idx, logic [15:0] value);
    req_item_t item;
    item.req_type    = kind;
    item.reg_index   = idx;
    item.write_value = value;
    return item;
  endfunction

  // Mostly ticks and writes that keep the counter wrapping often
  function automatic req_item_t random_request();
    req_item_t item;
    int        pick;
    item.req_type    = REQ_TICK;
    item.reg_index   = 3'($urandom);
    item.write_value = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      item.req_type = REQ_TICK;
    end else if (pick < 70) begin
      item.req_type = REQ_READ;
    end else if (pick < 95) begin
      item.req_type = REQ_WRITE;
      case ($urandom_range(0, 9))
        0, 1:    item.reg_index = REG_CTRL;
        2:       item.reg_index = REG_INT_EN;
        3:       item.reg_index = REG_STATUS;
        4, 5:    item.reg_index = REG_COUNTER;
        6:       item.reg_index = REG_PRESCALE;
        7, 8:    item.reg_index = REG_RELOAD;
        default: ;
      endcase
      case (item.reg_index)
        REG_CTRL: if ($urandom_range(0, 6) != 0) item.write_value[CTRL_EN_BIT] = 1'b1;
        REG_COUNTER: begin
          case ($urandom_range(0, 3))
            0, 1:    item.write_value = 16'($urandom_range(0, 12));
            2:       item.write_value = 16'hFFF0 | 16'($urandom_range(0, 15));
            default: ;
          endcase
        end
        REG_PRESCALE: if ($urandom_range(0, 4) != 0) item.write_value = 16'($urandom_range(0, 3));
        REG_RELOAD:   if ($urandom_range(0, 4) < 3) item.write_value = 16'($urandom_range(0, 10));
        default: ;
      endcase
    end else begin
      item.req_type = REQ_IDLE;
    end
    return item;
  endfunction

  // Offer one transaction, optionally after an idle burst; valid stays high afterwards
  task automatic send_item(input req_item_t item);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Monitor both channels and track cycles without any transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (!rst);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, unused registers and request type, disabled tick
    send_item(make_req(REQ_READ, REG_RELOAD, 16'h0000));
    send_item(make_req(REQ_READ, REG_RSVD6, 16'h0000));
    send_item(make_req(REQ_WRITE, REG_RSVD7, 16'hFFFF));
    send_item(make_req(REQ_IDLE, REG_STATUS, 16'hA5A5));
    send_item(make_req(REQ_TICK, REG_CTRL, 16'h0000));
    // count up to a small reload, junk control bits ignored
    send_item(make_req(REQ_WRITE, REG_INT_EN, 16'hFFFF));
    send_item(make_req(REQ_WRITE, REG_PRESCALE, 16'h0000));
    send_item(make_req(REQ_WRITE, REG_RELOAD, 16'h0002));
    send_item(make_req(REQ_WRITE, REG_CTRL, 16'hFF6F));
    repeat (3) send_item(make_req(REQ_TICK, REG_CTRL, 16'h0000));
    // status: writing 1 keeps the flag, writing 0 clears it
    send_item(make_req(REQ_READ, REG_STATUS, 16'h0000));
    send_item(make_req(REQ_WRITE, REG_STATUS, 16'hFFFF));
    send_item(make_req(REQ_WRITE, REG_STATUS, 16'hFFFE));
    // counter above the reload value rolls over without an update
    send_item(make_req(REQ_WRITE, REG_COUNTER, 16'hFFFF));
    send_item(make_req(REQ_TICK, REG_CTRL, 16'h0000));
    // count down with preload: new reload only taken at the wrap
    send_item(make_req(REQ_WRITE, REG_CTRL, 16'h0091));
    send_item(make_req(REQ_WRITE, REG_RELOAD, 16'h0005));
    send_item(make_req(REQ_TICK, REG_CTRL, 16'h0000));
    send_item(make_req(REQ_READ, REG_COUNTER, 16'h0000));
    // prescaler lowered below the running prescale count
    send_item(make_req(REQ_WRITE, REG_PRESCALE, 16'h0003));
    repeat (2) send_item(make_req(REQ_TICK, REG_CTRL, 16'h0000));
    send_item(make_req(REQ_WRITE, REG_PRESCALE, 16'h0000));
    send_item(make_req(REQ_TICK, REG_CTRL, 16'h0000));
    send_item(make_req(REQ_READ, REG_CTRL, 16'h0000));

    // Random traffic in segments; one long output hold-off, quiet tail
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) idling_on = (i < N_RANDOM - 150) && ($urandom_range(0, 3) != 0);
      if (i == 400) begin
        idling_on = 1'b0;
        hold_req  = 1'b1;
      end
      send_item(random_request());
    end
    req_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

    $display("Covered %0d transactions and %0d results: %0d counter updates, %0d with irq",
             sb.req_count, sb.rsp_count, sb.wrap_count, sb.irq_count);
    $display("Ticks, reads and writes over all register indexes, stalls on both sides");
    if (sb.error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
